// ===== sv/spct_pkg.sv =====
// Package for the shape pair collision test: widths, kind codes, shape type and helpers.
`default_nettype none

package spct_pkg;

  // Field and coordinate widths.
  localparam int FIELD_WIDTH = 32;
  localparam int KIND_WIDTH  = 2;
  localparam int PAIR_WIDTH  = 4;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Operand, product and sum widths of the distance datapath.
  localparam int OPER_WIDTH = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * OPER_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  // Number of multipliers in the product stage.
  localparam int NUM_MUL = 5;

  // Shape kinds.
  localparam logic [KIND_WIDTH-1:0] KIND_PLANE  = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_CIRCLE = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_BOX    = 2'd2;

  // Pair codes with a fixed meaning.
  localparam logic [PAIR_WIDTH-1:0] PAIR_PLANE_PLANE = 4'd0;
  localparam logic [PAIR_WIDTH-1:0] PAIR_INVALID     = 4'd15;

  // Test selected for a pair.
  localparam logic [2:0] TEST_NONE   = 3'd0;
  localparam logic [2:0] TEST_CPL    = 3'd1;
  localparam logic [2:0] TEST_PBOX   = 3'd2;
  localparam logic [2:0] TEST_WITHIN = 3'd3;
  localparam logic [2:0] TEST_BOX    = 3'd4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OPER_WIDTH-1:0]  oper_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  typedef struct packed {
    logic [KIND_WIDTH-1:0] kind;
    coord_t                x0;
    coord_t                y0;
    coord_t                x1;
    coord_t                y1;
    coord_t                s;
  } shape_t;

  // Low coordinate bits of a field, read as a signed value.
  function automatic coord_t to_coord(input logic [FIELD_WIDTH-1:0] f);
    logic [COORD_WIDTH-1:0] raw;
    raw = COORD_WIDTH'(f);
    return $signed(raw);
  endfunction

  // Clamp one axis: the max bound wins when the box is inverted.
  function automatic coord_t clamp_axis(input coord_t v, input coord_t lo, input coord_t hi);
    coord_t t;
    t = (v < lo) ? lo : v;
    return (t > hi) ? hi : t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/spct_in_if.sv =====
// Interfaces of the shape pair collision test: the pair channel and the result channel.
`default_nettype none

interface spct_in_if import spct_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic [KIND_WIDTH-1:0]          kind_a;
  logic signed [FIELD_WIDTH-1:0]  a_x0;
  logic signed [FIELD_WIDTH-1:0]  a_y0;
  logic signed [FIELD_WIDTH-1:0]  a_x1;
  logic signed [FIELD_WIDTH-1:0]  a_y1;
  logic signed [FIELD_WIDTH-1:0]  a_scalar;
  logic [KIND_WIDTH-1:0]          kind_b;
  logic signed [FIELD_WIDTH-1:0]  b_x0;
  logic signed [FIELD_WIDTH-1:0]  b_y0;
  logic signed [FIELD_WIDTH-1:0]  b_x1;
  logic signed [FIELD_WIDTH-1:0]  b_y1;
  logic signed [FIELD_WIDTH-1:0]  b_scalar;

  modport source (
    output valid, kind_a, a_x0, a_y0, a_x1, a_y1, a_scalar,
           kind_b, b_x0, b_y0, b_x1, b_y1, b_scalar,
    input  ready
  );
  modport sink (
    input  valid, kind_a, a_x0, a_y0, a_x1, a_y1, a_scalar,
           kind_b, b_x0, b_y0, b_x1, b_y1, b_scalar,
    output ready
  );
endinterface

interface spct_out_if import spct_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [PAIR_WIDTH-1:0] pair_code;

  modport source (output valid, hit, pair_code, input ready);
  modport sink (input valid, hit, pair_code, output ready);
endinterface

`default_nettype wire

// ===== sv/shape_pair_collision_test.sv =====
// Shape pair collision test: four-register pipeline that reports whether two 2D shapes touch.
//
// Usage: each word on in_chan carries two shapes (plane, circle or box, Q16.16) and
// their kinds. Each word on out_chan carries hit and pair_code (kind_a * 3 + kind_b,
// or 15 when either kind is 3). Both channels move a word when valid and ready are high.
// Pipeline: input register, operand register (ordering, differences, clamping, box
// overlap), product register (five signed multipliers), result register (sums and
// compares). Throughput is one word per cycle while out_chan keeps taking words; the
// five multipliers set the cycle time.
// Every stage has its own valid bit and advances when the stage after it is empty or
// moving, so empty stages are filled even while a finished result waits on out_chan.
// in_chan.ready drops only when all four stages hold a word and the receiver stalls.
// Reset (rst_n low, synchronous) empties all stages; no word is lost or repeated
// across a stall.
`default_nettype none

module shape_pair_collision_test import spct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  spct_in_if.sink   in_chan,
  spct_out_if.source out_chan
);

  // Stage valids and advance conditions.
  logic s0_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  logic adv_s0, adv_s1, adv_s2, adv_out;

  assign adv_out = !out_valid_r || out_chan.ready;
  assign adv_s2  = !s2_valid_r || adv_out;
  assign adv_s1  = !s1_valid_r || adv_s2;
  assign adv_s0  = !s0_valid_r || adv_s1;
  assign in_chan.ready = adv_s0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_s0)  s0_valid_r  <= in_chan.valid;
      if (adv_s1)  s1_valid_r  <= s0_valid_r;
      if (adv_s2)  s2_valid_r  <= s1_valid_r;
      if (adv_out) out_valid_r <= s2_valid_r;
    end
  end

  // Input register: capture both shapes as signed coordinates.
  shape_t sa_r, sb_r, sa_nxt, sb_nxt;

  always_comb begin
    sa_nxt.kind = in_chan.kind_a;
    sa_nxt.x0   = to_coord(in_chan.a_x0);
    sa_nxt.y0   = to_coord(in_chan.a_y0);
    sa_nxt.x1   = to_coord(in_chan.a_x1);
    sa_nxt.y1   = to_coord(in_chan.a_y1);
    sa_nxt.s    = to_coord(in_chan.a_scalar);
    sb_nxt.kind = in_chan.kind_b;
    sb_nxt.x0   = to_coord(in_chan.b_x0);
    sb_nxt.y0   = to_coord(in_chan.b_y0);
    sb_nxt.x1   = to_coord(in_chan.b_x1);
    sb_nxt.y1   = to_coord(in_chan.b_y1);
    sb_nxt.s    = to_coord(in_chan.b_scalar);
  end

  always_ff @(posedge clk) begin
    if (adv_s0 && in_chan.valid) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
  end

  // Operand stage: order the shapes by kind, pick the test and set up multiplier operands.
  oper_t                 op_a_r [NUM_MUL];
  oper_t                 op_b_r [NUM_MUL];
  oper_t                 op_a_nxt [NUM_MUL];
  oper_t                 op_b_nxt [NUM_MUL];
  coord_t                dist_r, dist_nxt;
  coord_t                rad_r, rad_nxt;
  logic                  rneg_r, rneg_nxt;
  logic                  box_hit_r, box_hit_nxt;
  logic [2:0]            test1_r, test1_nxt;
  logic [PAIR_WIDTH-1:0] pair1_r, pair1_nxt;

  always_comb begin
    shape_t p, q;
    coord_t qx, qy;
    oper_t  dx, dy, rsum;
    logic   swap;

    swap = sa_r.kind > sb_r.kind;
    p    = swap ? sb_r : sa_r;
    q    = swap ? sa_r : sb_r;
    qx   = clamp_axis(p.x0, q.x0, q.x1);
    qy   = clamp_axis(p.y0, q.y0, q.y1);
    dx   = '0;
    dy   = '0;
    rsum = '0;

    for (int i = 0; i < NUM_MUL; i++) begin
      op_a_nxt[i] = '0;
      op_b_nxt[i] = '0;
    end
    dist_nxt    = '0;
    rad_nxt     = '0;
    rneg_nxt    = 1'b0;
    box_hit_nxt = 1'b0;
    test1_nxt   = TEST_NONE;
    pair1_nxt   = PAIR_WIDTH'({2'b00, sa_r.kind} * 4'd3 + {2'b00, sb_r.kind});

    case ({p.kind, q.kind})
      {KIND_PLANE, KIND_CIRCLE}: begin
        // Plane distance of the circle center against the radius.
        test1_nxt   = TEST_CPL;
        op_a_nxt[0] = OPER_WIDTH'(p.x0);
        op_b_nxt[0] = OPER_WIDTH'(q.x0);
        op_a_nxt[2] = OPER_WIDTH'(p.y0);
        op_b_nxt[2] = OPER_WIDTH'(q.y0);
        dist_nxt    = p.s;
        rad_nxt     = q.s;
      end
      {KIND_PLANE, KIND_BOX}: begin
        // The four corners share two x products and two y products.
        test1_nxt   = TEST_PBOX;
        op_a_nxt[0] = OPER_WIDTH'(p.x0);
        op_b_nxt[0] = OPER_WIDTH'(q.x0);
        op_a_nxt[1] = OPER_WIDTH'(p.x0);
        op_b_nxt[1] = OPER_WIDTH'(q.x1);
        op_a_nxt[2] = OPER_WIDTH'(p.y0);
        op_b_nxt[2] = OPER_WIDTH'(q.y0);
        op_a_nxt[3] = OPER_WIDTH'(p.y0);
        op_b_nxt[3] = OPER_WIDTH'(q.y1);
        dist_nxt    = p.s;
      end
      {KIND_CIRCLE, KIND_CIRCLE}: begin
        test1_nxt   = TEST_WITHIN;
        dx          = OPER_WIDTH'(p.x0) - OPER_WIDTH'(q.x0);
        dy          = OPER_WIDTH'(p.y0) - OPER_WIDTH'(q.y0);
        rsum        = OPER_WIDTH'(p.s) + OPER_WIDTH'(q.s);
        op_a_nxt[0] = dx;
        op_b_nxt[0] = dx;
        op_a_nxt[2] = dy;
        op_b_nxt[2] = dy;
        op_a_nxt[4] = rsum;
        op_b_nxt[4] = rsum;
        rneg_nxt    = rsum[OPER_WIDTH-1];
      end
      {KIND_CIRCLE, KIND_BOX}: begin
        // Distance from the center to its clamp point inside the box.
        test1_nxt   = TEST_WITHIN;
        dx          = OPER_WIDTH'(qx) - OPER_WIDTH'(p.x0);
        dy          = OPER_WIDTH'(qy) - OPER_WIDTH'(p.y0);
        op_a_nxt[0] = dx;
        op_b_nxt[0] = dx;
        op_a_nxt[2] = dy;
        op_b_nxt[2] = dy;
        op_a_nxt[4] = OPER_WIDTH'(p.s);
        op_b_nxt[4] = OPER_WIDTH'(p.s);
        rneg_nxt    = p.s[COORD_WIDTH-1];
      end
      {KIND_BOX, KIND_BOX}: begin
        test1_nxt   = TEST_BOX;
        box_hit_nxt = (p.x0 <= q.x1) && (p.y0 <= q.y1) &&
                      (p.x1 >= q.x0) && (p.y1 >= q.y0);
      end
      default: begin
        test1_nxt = TEST_NONE;
      end
    endcase

    // A kind of 3 on either side gives no test and the invalid pair code.
    if (sa_r.kind > KIND_BOX || sb_r.kind > KIND_BOX) begin
      test1_nxt = TEST_NONE;
      pair1_nxt = PAIR_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1 && s0_valid_r) begin
      op_a_r    <= op_a_nxt;
      op_b_r    <= op_b_nxt;
      dist_r    <= dist_nxt;
      rad_r     <= rad_nxt;
      rneg_r    <= rneg_nxt;
      box_hit_r <= box_hit_nxt;
      test1_r   <= test1_nxt;
      pair1_r   <= pair1_nxt;
    end
  end

  // Product stage: five independent signed multipliers.
  prod_t                 prod_r [NUM_MUL];
  prod_t                 prod_nxt [NUM_MUL];
  coord_t                dist2_r, rad2_r;
  logic                  rneg2_r, box_hit2_r;
  logic [2:0]            test2_r;
  logic [PAIR_WIDTH-1:0] pair2_r;

  always_comb begin
    for (int i = 0; i < NUM_MUL; i++) begin
      prod_nxt[i] = op_a_r[i] * op_b_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s2 && s1_valid_r) begin
      prod_r     <= prod_nxt;
      dist2_r    <= dist_r;
      rad2_r     <= rad_r;
      rneg2_r    <= rneg_r;
      box_hit2_r <= box_hit_r;
      test2_r    <= test1_r;
      pair2_r    <= pair1_r;
    end
  end

  // Result stage: plane distances, squared distance compare and final selection.
  logic                  out_hit_r, hit_nxt;
  logic [PAIR_WIDTH-1:0] out_pair_r;

  always_comb begin
    sum_t d_sh, r_sh, s00, s10, s01, s11, sq_sum, sq_rad;

    d_sh   = sum_t'(dist2_r) <<< FRAC_BITS;
    r_sh   = sum_t'(rad2_r) <<< FRAC_BITS;
    s00    = sum_t'(prod_r[0]) + sum_t'(prod_r[2]) - d_sh;
    s10    = sum_t'(prod_r[1]) + sum_t'(prod_r[2]) - d_sh;
    s01    = sum_t'(prod_r[0]) + sum_t'(prod_r[3]) - d_sh;
    s11    = sum_t'(prod_r[1]) + sum_t'(prod_r[3]) - d_sh;
    sq_sum = sum_t'(prod_r[0]) + sum_t'(prod_r[2]);
    sq_rad = sum_t'(prod_r[4]);

    case (test2_r)
      TEST_CPL:    hit_nxt = (s00 < r_sh) && ((-s00) < r_sh);
      TEST_PBOX:   hit_nxt = s00[SUM_WIDTH-1] || s10[SUM_WIDTH-1] ||
                             s01[SUM_WIDTH-1] || s11[SUM_WIDTH-1];
      TEST_WITHIN: hit_nxt = !rneg2_r && (sq_sum <= sq_rad);
      TEST_BOX:    hit_nxt = box_hit2_r;
      default:     hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_out && s2_valid_r) begin
      out_hit_r  <= hit_nxt;
      out_pair_r <= pair2_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.hit       = out_hit_r;
  assign out_chan.pair_code = out_pair_r;

  // Checks on the pipeline control and the result encoding.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s0_valid_r && s1_valid_r && s2_valid_r && out_valid_r)
    else $error("input stalled while a pipeline stage is empty");

  a_s0_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && adv_s1 |=> s1_valid_r)
    else $error("word lost between input and operand stage");

  a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && adv_out |=> out_valid_r)
    else $error("word lost between product and result stage");

  a_plane_plane_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pair_r == PAIR_PLANE_PLANE |-> !out_hit_r)
    else $error("plane against plane reported a hit");

  a_invalid_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pair_r == PAIR_INVALID |-> !out_hit_r)
    else $error("invalid kind pair reported a hit");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the shape pair collision test: directed table, then random pairs.
module testbench import spct_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Q16.16 constants and coordinate extremes.
  localparam int ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;

  // Kind code that selects no test.
  localparam logic [KIND_WIDTH-1:0] KIND_BAD = 2'd3;

  // Pair codes, kind_a * 3 + kind_b.
  localparam logic [PAIR_WIDTH-1:0] PC_PLANE_CIRCLE  = 4'd1;
  localparam logic [PAIR_WIDTH-1:0] PC_PLANE_BOX     = 4'd2;
  localparam logic [PAIR_WIDTH-1:0] PC_CIRCLE_PLANE  = 4'd3;
  localparam logic [PAIR_WIDTH-1:0] PC_CIRCLE_CIRCLE = 4'd4;
  localparam logic [PAIR_WIDTH-1:0] PC_CIRCLE_BOX    = 4'd5;
  localparam logic [PAIR_WIDTH-1:0] PC_BOX_PLANE     = 4'd6;
  localparam logic [PAIR_WIDTH-1:0] PC_BOX_CIRCLE    = 4'd7;
  localparam logic [PAIR_WIDTH-1:0] PC_BOX_BOX       = 4'd8;

  localparam int RANDOM_PAIRS = 1250;
  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 1000;
  localparam int SETTLE       = 8;

  // Wide enough for a sum of three exact products of 33-bit operands.
  typedef logic signed [79:0] acc_t;
  localparam acc_t FRAC_SCALE = 80'sd65536;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]  kind;
    logic [FIELD_WIDTH-1:0] x0;
    logic [FIELD_WIDTH-1:0] y0;
    logic [FIELD_WIDTH-1:0] x1;
    logic [FIELD_WIDTH-1:0] y1;
    logic [FIELD_WIDTH-1:0] sc;
  } shape_word_t;

  typedef struct packed {
    shape_word_t a;
    shape_word_t b;
  } pair_t;

  typedef struct packed {
    logic                  hit;
    logic [PAIR_WIDTH-1:0] code;
  } verdict_t;

  typedef struct packed {
    pair_t    pr;
    logic     typed;
    verdict_t want;
  } row_t;

  logic clk;
  logic rst_n;

  spct_in_if  pair_if ();
  spct_out_if verdict_if ();

  shape_pair_collision_test DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pair_if),
    .out_chan (verdict_if)
  );

  // Side information that travels with the word on offer.
  logic     row_typed;
  verdict_t row_want;
  logic     hold_req;

  row_t     table_rows[$];
  verdict_t contact_q[$];
  int       errors;
  int       stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Low coordinate bits of each field, taken as two's complement.
  function automatic shape_t decode_shape(input shape_word_t w);
    shape_t s;
    s.kind = w.kind;
    s.x0   = $signed(w.x0[COORD_WIDTH-1:0]);
    s.y0   = $signed(w.y0[COORD_WIDTH-1:0]);
    s.x1   = $signed(w.x1[COORD_WIDTH-1:0]);
    s.y1   = $signed(w.y1[COORD_WIDTH-1:0]);
    s.s    = $signed(w.sc[COORD_WIDTH-1:0]);
    return s;
  endfunction

  function automatic acc_t widen(input coord_t v);
    return acc_t'(v);
  endfunction

  // Signed distance of a point from a plane, scaled by 2^32.
  function automatic acc_t signed_dist(input shape_t pl, input acc_t px, input acc_t py);
    return widen(pl.x0) * px + widen(pl.y0) * py - widen(pl.s) * FRAC_SCALE;
  endfunction

  // A point offset (dx, dy) lies within a disc of radius r.
  function automatic logic in_disc(input acc_t dx, input acc_t dy, input acc_t r);
    if (r < 0) return 1'b0;
    return !(r * r < dx * dx + dy * dy);
  endfunction

  // Clamp to [lo, hi], where the upper bound wins for an inverted box.
  function automatic acc_t nearest_on_axis(input acc_t v, input acc_t lo, input acc_t hi);
    acc_t t;
    t = (v < lo) ? lo : v;
    return (t > hi) ? hi : t;
  endfunction

  function automatic verdict_t predict_contact(input pair_t pr);
    shape_t   a, b, p, q;
    verdict_t v;
    acc_t     d, qx, qy;
    a = decode_shape(pr.a);
    b = decode_shape(pr.b);
    v.hit = 1'b0;
    if (a.kind > KIND_BOX || b.kind > KIND_BOX) begin
      v.code = PAIR_INVALID;
      return v;
    end
    v.code = PAIR_WIDTH'(a.kind * 3 + b.kind);
    // The lower kind goes first, so each test sees one order only.
    if (a.kind <= b.kind) begin
      p = a;
      q = b;
    end else begin
      p = b;
      q = a;
    end
    if (p.kind == KIND_PLANE && q.kind == KIND_CIRCLE) begin
      d = signed_dist(p, widen(q.x0), widen(q.y0));
      if (d < 0) d = -d;
      v.hit = d < widen(q.s) * FRAC_SCALE;
    end else if (p.kind == KIND_PLANE && q.kind == KIND_BOX) begin
      v.hit = signed_dist(p, widen(q.x0), widen(q.y0)) < 0 ||
              signed_dist(p, widen(q.x1), widen(q.y0)) < 0 ||
              signed_dist(p, widen(q.x0), widen(q.y1)) < 0 ||
              signed_dist(p, widen(q.x1), widen(q.y1)) < 0;
    end else if (p.kind == KIND_CIRCLE && q.kind == KIND_CIRCLE) begin
      v.hit = in_disc(widen(p.x0) - widen(q.x0), widen(p.y0) - widen(q.y0),
                      widen(p.s) + widen(q.s));
    end else if (p.kind == KIND_CIRCLE && q.kind == KIND_BOX) begin
      qx = nearest_on_axis(widen(p.x0), widen(q.x0), widen(q.x1));
      qy = nearest_on_axis(widen(p.y0), widen(q.y0), widen(q.y1));
      v.hit = in_disc(qx - widen(p.x0), qy - widen(p.y0), widen(p.s));
    end else if (p.kind == KIND_BOX) begin
      v.hit = p.x0 <= q.x1 && p.y0 <= q.y1 && p.x1 >= q.x0 && p.y1 >= q.y0;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Shape builders and random pairs
  // ---------------------------------------------------------------------------

  function automatic shape_word_t plane(input logic [31:0] nx, ny, d);
    return '{kind: KIND_PLANE, x0: nx, y0: ny, x1: 32'd0, y1: 32'd0, sc: d};
  endfunction

  function automatic shape_word_t circle(input logic [31:0] cx, cy, r);
    return '{kind: KIND_CIRCLE, x0: cx, y0: cy, x1: 32'd0, y1: 32'd0, sc: r};
  endfunction

  function automatic shape_word_t box(input logic [31:0] x0, y0, x1, y1);
    return '{kind: KIND_BOX, x0: x0, y0: y0, x1: x1, y1: y1, sc: 32'd0};
  endfunction

  // Every field set to the same value.
  function automatic shape_word_t flat(input logic [KIND_WIDTH-1:0] k, input logic [31:0] v);
    return '{kind: k, x0: v, y0: v, x1: v, y1: v, sc: v};
  endfunction

  function automatic row_t row(input shape_word_t a, b, input logic typed,
                               input logic hit, input logic [PAIR_WIDTH-1:0] code);
    row_t r;
    r.pr   = '{a: a, b: b};
    r.typed = typed;
    r.want = '{hit: hit, code: code};
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input row_t r);
    table_rows.insert(table_rows.size(), r);
  endfunction

  // Coordinate within +-8.0, where most contacts happen.
  function automatic logic [31:0] near_coord();
    return $urandom_range(0, 16 * ONE) - 8 * ONE;
  endfunction

  function automatic logic [31:0] edge_coord();
    case ($urandom_range(0, 3))
      0: return MINV;
      1: return MAXV;
      2: return 32'd0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic shape_word_t rand_shape();
    shape_word_t s;
    int          style;
    logic [31:0] t;
    s.kind = ($urandom_range(0, 31) == 0) ? KIND_BAD : KIND_WIDTH'($urandom_range(0, 2));
    // Fields that the kind ignores carry noise.
    s.x0 = $urandom;
    s.y0 = $urandom;
    s.x1 = $urandom;
    s.y1 = $urandom;
    s.sc = $urandom;
    style = $urandom_range(0, 9);
    if (style == 1) begin
      s.x0 = edge_coord();
      s.y0 = edge_coord();
      s.x1 = edge_coord();
      s.y1 = edge_coord();
      s.sc = edge_coord();
    end else if (style > 1) begin
      s.x0 = near_coord();
      s.y0 = near_coord();
      case (s.kind)
        KIND_PLANE: begin
          s.x0 = $urandom_range(0, 2 * ONE) - ONE;
          s.y0 = $urandom_range(0, 2 * ONE) - ONE;
          s.sc = near_coord();
        end
        KIND_CIRCLE: begin
          if ($urandom_range(0, 9) == 0) s.sc = -$urandom_range(1, ONE);
          else s.sc = $urandom_range(0, 4 * ONE);
        end
        KIND_BOX: begin
          s.x1 = s.x0 + $urandom_range(0, 4 * ONE);
          s.y1 = s.y0 + $urandom_range(0, 4 * ONE);
          // Now and then an inverted box on one axis.
          if ($urandom_range(0, 9) == 0) begin
            t    = s.x0;
            s.x0 = s.x1;
            s.x1 = t;
          end
        end
        default: ;
      endcase
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one word and return at the edge that accepts it.
  task automatic offer(input pair_t p, input logic typed, input verdict_t want);
    pair_if.valid    <= 1'b1;
    pair_if.kind_a   <= p.a.kind;
    pair_if.a_x0     <= p.a.x0;
    pair_if.a_y0     <= p.a.y0;
    pair_if.a_x1     <= p.a.x1;
    pair_if.a_y1     <= p.a.y1;
    pair_if.a_scalar <= p.a.sc;
    pair_if.kind_b   <= p.b.kind;
    pair_if.b_x0     <= p.b.x0;
    pair_if.b_y0     <= p.b.y0;
    pair_if.b_x1     <= p.b.x1;
    pair_if.b_y1     <= p.b.y1;
    pair_if.b_scalar <= p.b.sc;
    row_typed        <= typed;
    row_want         <= want;
    do @(posedge clk); while (pair_if.ready !== 1'b1);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      pair_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    pair_if.valid <= 1'b0;
    @(posedge clk);
    while (contact_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int   sent, burst, next_squeeze, next_drain;

    rst_n     <= 1'b0;
    hold_req  <= 1'b0;
    row_typed <= 1'b0;
    row_want  <= '0;
    pair_if.valid    <= 1'b0;
    pair_if.kind_a   <= '0;
    pair_if.a_x0     <= '0;
    pair_if.a_y0     <= '0;
    pair_if.a_x1     <= '0;
    pair_if.a_y1     <= '0;
    pair_if.a_scalar <= '0;
    pair_if.kind_b   <= '0;
    pair_if.b_x0     <= '0;
    pair_if.b_y0     <= '0;
    pair_if.b_x1     <= '0;
    pair_if.b_y1     <= '0;
    pair_if.b_scalar <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs: every pair code, the invalid kind and the boundary cases.
    add_row(row(flat(KIND_PLANE, MAXV), flat(KIND_PLANE, MINV),
                1'b1, 1'b0, PAIR_PLANE_PLANE));
    add_row(row(flat(KIND_BAD, MAXV), circle(0, 0, ONE),
                1'b1, 1'b0, PAIR_INVALID));
    add_row(row(circle(0, 0, ONE), flat(KIND_BAD, MINV),
                1'b1, 1'b0, PAIR_INVALID));
    add_row(row(flat(KIND_BAD, 0), flat(KIND_BAD, 0),
                1'b1, 1'b0, PAIR_INVALID));
    add_row(row(circle(0, 0, ONE), plane(ONE, 0, 0),
                1'b1, 1'b1, PC_CIRCLE_PLANE));
    // Circle just touching the plane: the radius must exceed the distance.
    add_row(row(plane(ONE, 0, 0), circle(ONE, 0, ONE),
                1'b1, 1'b0, PC_PLANE_CIRCLE));
    // Zero normal: the distance is -d everywhere.
    add_row(row(plane(0, 0, -5 * ONE), circle(0, 0, 4 * ONE),
                1'b0, 1'b0, '0));
    add_row(row(plane(0, 0, -5 * ONE), circle(3 * ONE, 0, 6 * ONE),
                1'b0, 1'b0, '0));
    add_row(row(plane(ONE, 0, 0), circle(0, 0, -ONE),
                1'b1, 1'b0, PC_PLANE_CIRCLE));
    add_row(row(circle(0, 0, 0), circle(0, 0, 0),
                1'b1, 1'b1, PC_CIRCLE_CIRCLE));
    add_row(row(circle(0, 0, ONE), circle(2 * ONE, 0, ONE),
                1'b1, 1'b1, PC_CIRCLE_CIRCLE));
    // Negative radius sum never hits.
    add_row(row(circle(0, 0, ONE), circle(0, 0, -2 * ONE),
                1'b1, 1'b0, PC_CIRCLE_CIRCLE));
    add_row(row(circle(MINV, MINV, MAXV), circle(MAXV, MAXV, MAXV),
                1'b0, 1'b0, '0));
    add_row(row(circle(ONE, ONE, 0), box(0, 0, 2 * ONE, 2 * ONE),
                1'b1, 1'b1, PC_CIRCLE_BOX));
    add_row(row(box(0, 0, ONE, ONE), circle(5 * ONE, 5 * ONE, -ONE),
                1'b1, 1'b0, PC_BOX_CIRCLE));
    // Inverted box: the clamp lands on the max corner.
    add_row(row(circle(0, 0, 2 * ONE), box(3 * ONE, 3 * ONE, -ONE, ONE),
                1'b0, 1'b0, '0));
    add_row(row(box(0, 0, ONE, ONE), box(ONE, ONE, 2 * ONE, 2 * ONE),
                1'b1, 1'b1, PC_BOX_BOX));
    add_row(row(box(0, 0, ONE, ONE), box(ONE + 1, 0, 2 * ONE, ONE),
                1'b1, 1'b0, PC_BOX_BOX));
    add_row(row(plane(ONE, 0, 0), box(-ONE, 0, ONE, ONE),
                1'b1, 1'b1, PC_PLANE_BOX));
    add_row(row(box(ONE, ONE, 2 * ONE, 2 * ONE), plane(ONE, ONE, 0),
                1'b1, 1'b0, PC_BOX_PLANE));
    add_row(row(plane(MINV, MAXV, MINV), box(MINV, MINV, MAXV, MAXV),
                1'b0, 1'b0, '0));
    add_row(row(box(MAXV, MAXV, MINV, MINV), circle(MINV, MAXV, MAXV),
                1'b0, 1'b0, '0));
    add_row(row(circle(MAXV, MINV, MAXV), plane(MINV, MINV, MAXV),
                1'b0, 1'b0, '0));
    add_row(row(flat(KIND_BOX, MINV), flat(KIND_BOX, MAXV),
                1'b0, 1'b0, '0));
    add_row(row(flat(KIND_PLANE, 32'hFFFF_FFFF), flat(KIND_BOX, MAXV),
                1'b0, 1'b0, '0));

    foreach (table_rows[i]) begin
      offer(table_rows[i].pr, table_rows[i].typed, table_rows[i].want);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 3));
    end
    drain();

    // Random pairs in bursts, with long receiver hold-offs and full drains.
    sent         = 0;
    next_squeeze = 300;
    next_drain   = 550;
    while (sent < RANDOM_PAIRS) begin
      if (sent >= next_squeeze) begin
        hold_req <= !hold_req;
        repeat (40) begin
          offer('{a: rand_shape(), b: rand_shape()}, 1'b0, '0);
          sent++;
        end
        next_squeeze += 500;
      end
      if (sent >= next_drain) begin
        drain();
        next_drain += 500;
      end
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        offer('{a: rand_shape(), b: rand_shape()}, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
    end

    // Wait for the last results, then a settling wait for anything stray.
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall styles that change at random intervals, plus hold-offs.
  // ---------------------------------------------------------------------------
  initial begin
    int   hold_left, style_left, style;
    logic hold_seen;
    hold_left  = 0;
    style_left = 0;
    style      = 0;
    hold_seen  = 1'b0;
    verdict_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req !== hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(10, 80);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        verdict_if.ready <= 1'b0;
      end else begin
        case (style)
          0: verdict_if.ready <= 1'b1;
          1: verdict_if.ready <= 1'($urandom_range(0, 1));
          2: verdict_if.ready <= (style_left % 3 != 0);
          default: verdict_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: queue the expected verdict of every accepted pair, check every accepted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : score
    pair_t    seen;
    verdict_t due;
    if (rst_n && pair_if.valid === 1'b1 && pair_if.ready === 1'b1) begin
      seen.a = '{kind: pair_if.kind_a, x0: pair_if.a_x0, y0: pair_if.a_y0,
                 x1: pair_if.a_x1, y1: pair_if.a_y1, sc: pair_if.a_scalar};
      seen.b = '{kind: pair_if.kind_b, x0: pair_if.b_x0, y0: pair_if.b_y0,
                 x1: pair_if.b_x1, y1: pair_if.b_y1, sc: pair_if.b_scalar};
      if (row_typed) contact_q.insert(contact_q.size(), row_want);
      else contact_q.insert(contact_q.size(), predict_contact(seen));
    end
    if (rst_n && verdict_if.valid === 1'b1 && verdict_if.ready === 1'b1) begin
      if (contact_q.size() == 0) begin
        $error("result word with no pair pending: hit %0b pair_code %0d",
               verdict_if.hit, verdict_if.pair_code);
        errors++;
      end else begin
        due = contact_q.pop_front();
        if (verdict_if.hit !== due.hit) begin
          $error("hit: expected %0b, got %0b", due.hit, verdict_if.hit);
          errors++;
        end
        if (verdict_if.pair_code !== due.code) begin
          $error("pair_code: expected %0d, got %0d", due.code, verdict_if.pair_code);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  initial begin
    errors       = 0;
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((pair_if.valid === 1'b1 && pair_if.ready === 1'b1) ||
          (verdict_if.valid === 1'b1 && verdict_if.ready === 1'b1)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
sv/spct_pkg.sv
sv/spct_in_if.sv
sv/shape_pair_collision_test.sv
tb/testbench.sv
